// File: sv/hklf_pkg.sv
// ----------------------------------------------------------------------------
// hklf_pkg: shared types and constants of the keyframe LED fader
// Register map codes, field widths and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package hklf_pkg;

    localparam int NUM_PIXELS_DEF = 6;
    localparam int TIME_BITS_DEF  = 8;
    localparam int MAX_PEAKS_DEF  = 4;

    localparam int ADDR_W  = 5;
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 10;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [2:0] REG_PEAK0      = 3'd0;
    localparam logic [2:0] REG_PEAK1      = 3'd1;
    localparam logic [2:0] REG_PEAK2      = 3'd2;
    localparam logic [2:0] REG_PEAK3      = 3'd3;
    localparam logic [2:0] REG_PEAK_COUNT = 3'd4;
    localparam logic [2:0] REG_REPEAT_CNT = 3'd5;
    localparam logic [2:0] REG_FOREVER    = 3'd6;
    localparam logic [2:0] REG_HUE_STEP   = 3'd7;

    localparam logic [2:0] PH_FADE_IN  = 3'd0;
    localparam logic [2:0] PH_ACTIVE   = 3'd1;
    localparam logic [2:0] PH_WRAP     = 3'd2;
    localparam logic [2:0] PH_FADE_OUT = 3'd3;
    localparam logic [2:0] PH_COMPLETE = 3'd4;

    typedef struct packed {
        logic [3:0][23:0] peak_hsl;
        logic [2:0]       peak_count;
        logic [6:0]       repeat_count;
        logic             repeat_forever;
        logic [7:0]       hue_step;
    } cfg_t;

    function automatic logic [23:0] peak_at(input logic [3:0][23:0] pk, input logic [1:0] k);
        return pk[k];
    endfunction

endpackage

`default_nettype wire

// File: sv/hsl_keyframe_led_fader.sv
// ----------------------------------------------------------------------------
// hsl_keyframe_led_fader: keyframe HSL color fader for an LED strip
// Steps the fade/keyframe sequence per poll and renders pixel colors.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | contents
//  s_      | in        | s_tvalid/s_tready  | poll word: tick, restart
//  m_      | out       | m_tvalid/m_tready  | pixel word, valid flag, last
//  apb     | in        | psel/penable       | keyframe and sequencing registers
//
//  A poll without tick sends a blank word; a render tick runs the lerp steps
//  and one pixel pass, plus another pass when a clearing frame is sent first.
//  The steps follow the single shared multiplier: three lerp products,
//  one chroma product, then one product per pixel.
//  Reset is synchronous; the sequence starts at fade in. A stalled m_ side
//  holds the sequencer, while one finished word waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_keyframe_led_fader #(
    parameter int NUM_PIXELS = hklf_pkg::NUM_PIXELS_DEF,
    parameter int TIME_BITS  = hklf_pkg::TIME_BITS_DEF,
    parameter int MAX_PEAKS  = hklf_pkg::MAX_PEAKS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // tick, restart
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [31:0]                 m_tdata,   // pixel_index, red, green, blue, phase
    output logic      [0:0]                  m_tuser,   // pixel_valid
    output logic                             m_tlast,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [hklf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready
);
    import hklf_pkg::*;

    localparam logic [7:0] HALF_OFF = 8'(NUM_PIXELS / 2);
    localparam logic [4:0] LAST_PIX = 5'(NUM_PIXELS - 1);
    localparam int         IDX_W    = 16 - TIME_BITS;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_BLANK = 9'b000000010,
        ST_HUE   = 9'b000000100,
        ST_SAT   = 9'b000001000,
        ST_LIT   = 9'b000010000,
        ST_CMUL  = 9'b000100000,
        ST_CWAIT = 9'b001000000,
        ST_XMUL  = 9'b010000000,
        ST_XGET  = 9'b100000000
    } state_t;

    cfg_t cfg;

    hklf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t state_reg, state_next;
    logic [2:0]  phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  repeats_reg, repeats_next;
    logic [7:0]  drift_reg, drift_next;

    // per-item work registers
    logic [2:0][7:0]                 from_reg, from_next;
    logic [2:0][MUL_A_W-1:0]         opa_reg, opa_next;
    logic [2:0][MUL_B_W-1:0]         opb_reg, opb_next;
    logic        lneg_reg, lneg_next;
    logic        multi_reg, multi_next;
    logic        clear_reg, clear_next;
    logic [7:0]  h_reg, h_next;
    logic [7:0]  s_reg, s_next;
    logic [7:0]  l_reg, l_next;
    logic [7:0]  c_reg, c_next;
    logic [7:0]  off_reg, off_next;
    logic [4:0]  pix_reg, pix_next;

    logic        ovalid_reg, ovalid_next;
    logic [31:0] odata_reg, odata_next;
    logic        ouser_reg, ouser_next;
    logic        olast_reg, olast_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    hklf_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    logic       accept;
    logic       out_free;
    logic [7:0] prod_hi;
    logic [7:0] lerp_q;
    logic [7:0] l_val;
    logic [7:0] ph;
    logic [10:0] hh;
    logic [8:0] h1;
    logic [8:0] xa;
    logic [8:0] l1;
    logic [9:0] ca;
    logic [7:0] off_start;
    logic [7:0] mval, rr, gg, bb;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !ovalid_reg || m_tready;
    assign lerp_q   = prod[TIME_BITS +: 8];
    assign prod_hi  = prod[15:8];

    assign l_val     = lneg_reg ? 8'(from_reg[2] - lerp_q) : 8'(from_reg[2] + lerp_q);
    assign l1        = {1'b0, l_val} + 9'd1;
    assign ca        = (l_val < 8'd128) ? {l1, 1'b0} : 10'(10'd512 - {l1, 1'b0});
    assign off_start = multi_reg ? 8'(8'd0 - 8'(HALF_OFF * cfg.hue_step)) : 8'd0;
    assign ph        = 8'(h_reg + off_reg);
    assign hh        = {1'b0, ph, 2'b00} + {2'b00, ph, 1'b0};
    assign h1        = {1'b0, hh[7:0]} + 9'd1;
    assign xa        = hh[8] ? 9'(9'd256 - h1) : h1;
    assign mval      = 8'(l_reg - {1'b0, c_reg[7:1]});

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_HUE: begin
                mul_a = opa_reg[0];
                mul_b = opb_reg[0];
            end
            ST_SAT: begin
                mul_a = opa_reg[1];
                mul_b = opb_reg[1];
            end
            ST_LIT: begin
                mul_a = opa_reg[2];
                mul_b = opb_reg[2];
            end
            ST_CMUL: begin
                mul_a = MUL_A_W'(ca);
                mul_b = MUL_B_W'(s_reg);
            end
            ST_XMUL, ST_XGET: begin
                mul_a = MUL_A_W'(xa);
                mul_b = MUL_B_W'(c_reg);
            end
            default: ;
        endcase
    end

    // pixel color from sector
    always_comb begin
        logic [7:0] x;
        logic [7:0] r, g, b;
        x = prod_hi;
        case (hh[10:8])
            3'd0: begin r = c_reg; g = x;     b = 8'd0;  end
            3'd1: begin r = x;     g = c_reg; b = 8'd0;  end
            3'd2: begin r = 8'd0;  g = c_reg; b = x;     end
            3'd3: begin r = 8'd0;  g = x;     b = c_reg; end
            3'd4: begin r = x;     g = 8'd0;  b = c_reg; end
            default: begin r = c_reg; g = 8'd0; b = x; end
        endcase
        if (clear_reg || l_reg == 8'd0) begin
            rr = 8'd0;
            gg = 8'd0;
            bb = 8'd0;
        end else begin
            rr = 8'(r + mval);
            gg = 8'(g + mval);
            bb = 8'(b + mval);
        end
    end

    // poll handling: phase update and lerp operand setup
    always_comb begin
        logic       tick, rst;
        logic [2:0] ph0, n, n_m1, n_m2;
        logic       multi;
        logic [15:0] pos0;
        logic [7:0] rl0, dr0;
        logic [23:0] first, lastp, pa, pb, p;
        logic [IDX_W-1:0] idx_w;
        logic [1:0] idx;
        logic [16:0] lim;
        logic [TIME_BITS-1:0] t;
        logic [9:0] hv;
        logic       cyc_end;

        tick = s_tdata[0];
        rst  = s_tdata[1];

        phase_next   = phase_reg;
        pos_next     = pos_reg;
        repeats_next = repeats_reg;
        drift_next   = drift_reg;
        from_next    = from_reg;
        opa_next     = opa_reg;
        opb_next     = opb_reg;
        lneg_next    = lneg_reg;
        multi_next   = multi_reg;
        clear_next   = clear_reg;

        ph0  = rst ? PH_FADE_IN : phase_reg;
        pos0 = rst ? 16'd0 : pos_reg;
        rl0  = rst ? {1'b0, cfg.repeat_count} : repeats_reg;
        dr0  = rst ? 8'd0 : drift_reg;

        if (cfg.peak_count == 3'd0) n = 3'd1;
        else if (cfg.peak_count > 3'(MAX_PEAKS)) n = 3'(MAX_PEAKS);
        else n = cfg.peak_count;
        multi = (n >= 3'd2);
        n_m1  = n - 3'd1;
        n_m2  = n - 3'd2;
        first = cfg.peak_hsl[0];
        lastp = peak_at(cfg.peak_hsl, n_m1[1:0]);
        if (ph0 > PH_COMPLETE) ph0 = PH_COMPLETE;
        if (!multi && ph0 == PH_WRAP) ph0 = PH_ACTIVE;

        t     = pos0[TIME_BITS-1:0];
        idx_w = pos0[15:TIME_BITS];
        idx   = (idx_w > IDX_W'(n_m2)) ? n_m2[1:0] : idx_w[1:0];
        lim   = 17'(n_m1) << TIME_BITS;
        pa    = 24'd0;
        pb    = 24'd0;
        p     = first;
        cyc_end = 1'b0;
        hv    = 10'd0;

        if (accept) begin
            multi_next = multi;
            clear_next = 1'b0;
            lneg_next  = 1'b0;
            opa_next   = '0;
            opb_next   = '0;
            from_next  = '0;

            if (ph0 == PH_FADE_IN || ph0 == PH_FADE_OUT) begin
                p = (ph0 == PH_FADE_IN || !multi) ? first : lastp;
                from_next[0] = p[23:16];
                from_next[1] = p[15:8];
                from_next[2] = (ph0 == PH_FADE_IN) ? 8'd0 : p[7:0];
                lneg_next    = (ph0 == PH_FADE_OUT);
                opa_next[2]  = MUL_A_W'(pos0);
                opb_next[2]  = MUL_B_W'(p[7:0]);
                pos_next = tick ? 16'(pos0 + 16'd2) : pos0;
                phase_next = ph0;
                if (pos_next[15:TIME_BITS] != '0) begin
                    pos_next = 16'd0;
                    if (ph0 == PH_FADE_IN) phase_next = PH_ACTIVE;
                    else begin
                        phase_next = PH_COMPLETE;
                        clear_next = multi;
                    end
                end
            end else if (ph0 == PH_ACTIVE || ph0 == PH_WRAP) begin
                if (multi) begin
                    pa = (ph0 == PH_WRAP) ? lastp : peak_at(cfg.peak_hsl, idx);
                    pb = (ph0 == PH_WRAP) ? first : peak_at(cfg.peak_hsl, 2'(idx + 2'd1));
                    // short-way hue delta in -127..127
                    hv = 10'd384 + {2'b0, pb[23:16]} - {2'b0, pa[23:16]};
                    if (hv >= 10'd510) hv = hv - 10'd510;
                    else if (hv >= 10'd255) hv = hv - 10'd255;
                    from_next[0] = pa[23:16];
                    from_next[1] = pa[15:8];
                    from_next[2] = pa[7:0];
                    opa_next[0]  = MUL_A_W'(t);
                    opa_next[1]  = MUL_A_W'(t);
                    opa_next[2]  = MUL_A_W'(t);
                    opb_next[0]  = MUL_B_W'(hv - 10'd127);
                    opb_next[1]  = {2'b0, pb[15:8]} - {2'b0, pa[15:8]};
                    opb_next[2]  = {2'b0, pb[7:0]} - {2'b0, pa[7:0]};
                    pos_next   = tick ? 16'(pos0 + 16'd1) : pos0;
                    phase_next = ph0;
                    if (ph0 == PH_WRAP) begin
                        if (pos_next[15:TIME_BITS] != '0) begin
                            pos_next   = 16'd0;
                            phase_next = PH_ACTIVE;
                        end
                    end else begin
                        cyc_end = ({1'b0, pos_next} >= lim);
                    end
                end else begin
                    from_next[1] = first[15:8];
                    from_next[2] = first[7:0];
                    pos_next   = pos0;
                    phase_next = ph0;
                    if (tick) begin
                        pos_next = 16'(pos0 + 16'd1);
                        dr0      = 8'(dr0 + 8'd1);
                        cyc_end  = (pos_next[15:TIME_BITS] != '0);
                    end
                end
                repeats_next = rl0;
                if (cyc_end) begin
                    pos_next = 16'd0;
                    if (!cfg.repeat_forever && rl0 == 8'd0) phase_next = PH_FADE_OUT;
                    else begin
                        if (!cfg.repeat_forever) repeats_next = 8'(rl0 - 8'd1);
                        phase_next = multi ? PH_WRAP : PH_ACTIVE;
                    end
                end
            end else begin
                pos_next   = pos0;
                phase_next = ph0;
            end

            if (!(ph0 == PH_ACTIVE || ph0 == PH_WRAP)) repeats_next = rl0;
            drift_next = dr0;
            if (!multi) begin
                from_next[0] = 8'(first[23:16] + dr0);
                opa_next[0]  = '0;
                opb_next[0]  = '0;
            end
        end else if (state_reg == ST_XGET && out_free && pix_reg == LAST_PIX) begin
            clear_next = 1'b0;
        end
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        h_next      = h_reg;
        s_next      = s_reg;
        l_next      = l_reg;
        c_next      = c_reg;
        off_next    = off_reg;
        pix_next    = pix_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;
        olast_next  = olast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = s_tdata[0] ? ST_HUE : ST_BLANK;
            end
            ST_BLANK: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    odata_next  = {phase_reg, 29'd0};
                    ouser_next  = 1'b0;
                    olast_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_HUE: state_next = ST_SAT;
            ST_SAT: begin
                h_next     = 8'(from_reg[0] + lerp_q);
                state_next = ST_LIT;
            end
            ST_LIT: begin
                s_next     = 8'(from_reg[1] + lerp_q);
                state_next = ST_CMUL;
            end
            ST_CMUL: begin
                l_next     = l_val;
                pix_next   = 5'd0;
                off_next   = off_start;
                state_next = ST_CWAIT;
            end
            ST_CWAIT: begin
                c_next     = prod_hi;
                state_next = ST_XMUL;
            end
            ST_XMUL: state_next = ST_XGET;
            ST_XGET: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    odata_next  = {phase_reg, bb, gg, rr, pix_reg};
                    ouser_next  = 1'b1;
                    olast_next  = !clear_reg && pix_reg == LAST_PIX;
                    state_next  = ST_XMUL;
                    if (pix_reg == LAST_PIX) begin
                        pix_next = 5'd0;
                        off_next = off_start;
                        if (!clear_reg) state_next = ST_IDLE;
                    end else begin
                        pix_next = pix_reg + 5'd1;
                        off_next = 8'(off_reg + cfg.hue_step);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_FADE_IN;
            pos_reg     <= 16'd0;
            repeats_reg <= 8'd0;
            drift_reg   <= 8'd0;
            ovalid_reg  <= 1'b0;
            clear_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            repeats_reg <= repeats_next;
            drift_reg   <= drift_next;
            ovalid_reg  <= ovalid_next;
            clear_reg   <= clear_next;
        end
    end

    always_ff @(posedge aclk) begin
        from_reg  <= from_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        lneg_reg  <= lneg_next;
        multi_reg <= multi_next;
        h_reg     <= h_next;
        s_reg     <= s_next;
        l_reg     <= l_next;
        c_reg     <= c_next;
        off_reg   <= off_next;
        pix_reg   <= pix_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg != ST_IDLE)
        else $error("sequencer stayed idle after taking a word");

    a_blank_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata[28:0] == 29'd0))
        else $error("poll word without tick is not a blank last word");

    a_phase_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:29] <= PH_COMPLETE)
        else $error("phase field out of range");

    a_clear_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_XGET && clear_reg && out_free) |-> !olast_next)
        else $error("clearing frame marked last");

endmodule

`default_nettype wire

// File: sv/hklf_cfg.sv
// ----------------------------------------------------------------------------
// hklf_cfg: configuration register file
// APB-style write and read of the keyframes and sequencing controls.
// ----------------------------------------------------------------------------
`default_nettype none

module hklf_cfg (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hklf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output hklf_pkg::cfg_t                  cfg
);
    import hklf_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{peak_hsl: '0, peak_count: 3'd1, repeat_count: 7'd0,
                         repeat_forever: 1'b0, hue_step: 8'd0};
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_PEAK0:      cfg_reg.peak_hsl[0]    <= pwdata[23:0];
                REG_PEAK1:      cfg_reg.peak_hsl[1]    <= pwdata[23:0];
                REG_PEAK2:      cfg_reg.peak_hsl[2]    <= pwdata[23:0];
                REG_PEAK3:      cfg_reg.peak_hsl[3]    <= pwdata[23:0];
                REG_PEAK_COUNT: cfg_reg.peak_count     <= pwdata[2:0];
                REG_REPEAT_CNT: cfg_reg.repeat_count   <= pwdata[6:0];
                REG_FOREVER:    cfg_reg.repeat_forever <= pwdata[0];
                REG_HUE_STEP:   cfg_reg.hue_step       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PEAK0:      prdata = {8'd0, cfg_reg.peak_hsl[0]};
            REG_PEAK1:      prdata = {8'd0, cfg_reg.peak_hsl[1]};
            REG_PEAK2:      prdata = {8'd0, cfg_reg.peak_hsl[2]};
            REG_PEAK3:      prdata = {8'd0, cfg_reg.peak_hsl[3]};
            REG_PEAK_COUNT: prdata = {29'd0, cfg_reg.peak_count};
            REG_REPEAT_CNT: prdata = {25'd0, cfg_reg.repeat_count};
            REG_FOREVER:    prdata = {31'd0, cfg_reg.repeat_forever};
            REG_HUE_STEP:   prdata = {24'd0, cfg_reg.hue_step};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/hklf_mul.sv
// ----------------------------------------------------------------------------
// hklf_mul: shared signed multiplier
// One registered signed product per cycle, reused for every lerp, the chroma and every pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module hklf_mul (
    input  wire logic                               aclk,
    input  wire logic signed [hklf_pkg::MUL_A_W-1:0] op_a,
    input  wire logic signed [hklf_pkg::MUL_B_W-1:0] op_b,
    output logic signed      [hklf_pkg::PROD_W-1:0]  prod
);
    import hklf_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire
